// ===== src/rec_pkg.sv =====
// ----------------------------------------------------------------------------
// rec_pkg
// Shared types and constants for the rotary encoder detent counter.
// ----------------------------------------------------------------------------
`default_nettype none

package rec_pkg;

    localparam int unsigned CountW  = 8;
    localparam int unsigned StepW   = 7;
    localparam int unsigned ThrW    = 8;
    localparam int unsigned IdleW   = 8;
    localparam int unsigned HistW   = 8;
    localparam int unsigned DirW    = 2;
    localparam int unsigned SumW    = CountW + 2;

    localparam logic [HistW-1:0] PAT_CW    = 8'hD2;
    localparam logic [HistW-1:0] PAT_CCW   = 8'hE1;
    localparam logic [IdleW-1:0] IDLE_MAX  = 8'd255;
    localparam logic [ThrW-1:0]  THR_RESET = 8'd6;
    localparam logic [StepW-1:0] STEP_RESET = 7'd4;

    localparam logic signed [SumW-1:0] COUNT_MAX = 10'sd127;
    localparam logic signed [SumW-1:0] COUNT_MIN = -10'sd128;

    localparam logic [DirW-1:0] DIR_NONE = 2'd0;
    localparam logic [DirW-1:0] DIR_CW   = 2'd1;
    localparam logic [DirW-1:0] DIR_CCW  = 2'd2;

    // register indexes on the configuration port
    localparam logic REG_SLOW_THRESHOLD = 1'b0;
    localparam logic REG_FAST_STEP      = 1'b1;

    typedef struct packed {
        logic [ThrW-1:0]  slow_threshold;
        logic [StepW-1:0] fast_step;
    } t_cfg;

    typedef struct packed {
        logic                     clear_count;
        logic                     pin_b;
        logic                     pin_a;
    } t_item;

    typedef struct packed {
        logic [HistW-1:0]         hist;
        logic [IdleW-1:0]         idle;
        logic signed [CountW-1:0] count;
    } t_state;

    typedef struct packed {
        logic                     fast_turn;
        logic [DirW-1:0]          detent_dir;
        logic signed [CountW-1:0] count;
    } t_result;

endpackage

`default_nettype wire

// ===== src/rec_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rec_cfg_regs
// APB register file holding the slow threshold and the fast step.
// ----------------------------------------------------------------------------
`default_nettype none

module rec_cfg_regs
    import rec_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_wr;
    logic w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[2];

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_SLOW_THRESHOLD: n_cfg.slow_threshold = pwdata[ThrW-1:0];
                REG_FAST_STEP:      n_cfg.fast_step      = pwdata[StepW-1:0];
                default:            n_cfg                = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slow_threshold <= THR_RESET;
            r_cfg.fast_step      <= STEP_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            REG_SLOW_THRESHOLD: prdata = {{(32-ThrW){1'b0}}, r_cfg.slow_threshold};
            REG_FAST_STEP:      prdata = {{(32-StepW){1'b0}}, r_cfg.fast_step};
            default:            prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/rec_step.sv =====
// ----------------------------------------------------------------------------
// rec_step
// Per-tick update: pin history, idle count, detent detection, saturating step.
// ----------------------------------------------------------------------------
`default_nettype none

module rec_step
    import rec_pkg::*;
(
    input  wire t_cfg    i_cfg,
    input  wire t_state  i_state,
    input  wire t_item   i_item,
    output t_state       o_state,
    output t_result      o_result
);

    logic [1:0]               w_io;
    logic                     w_change;
    logic [HistW-1:0]         w_hist_sh;
    logic                     w_cw;
    logic                     w_ccw;
    logic                     w_slow;
    logic [StepW-1:0]         w_step;
    logic signed [CountW-1:0] w_cnt0;
    logic signed [SumW-1:0]   w_cnt_ext;
    logic signed [SumW-1:0]   w_step_ext;
    logic signed [SumW-1:0]   w_sum;
    logic signed [CountW-1:0] w_sat;

    assign w_io      = {i_item.pin_b, i_item.pin_a};
    assign w_change  = (i_state.hist[1:0] != w_io);
    assign w_hist_sh = {i_state.hist[HistW-3:0], w_io};
    assign w_cw      = w_change && (w_hist_sh == PAT_CW);
    assign w_ccw     = w_change && (w_hist_sh == PAT_CCW);
    assign w_slow    = (i_state.idle > i_cfg.slow_threshold);
    assign w_step    = w_slow ? StepW'(1) : i_cfg.fast_step;

    // clear applies before the detent
    assign w_cnt0     = i_item.clear_count ? '0 : i_state.count;
    assign w_cnt_ext  = SumW'(w_cnt0);
    assign w_step_ext = $signed({{(SumW-StepW){1'b0}}, w_step});
    assign w_sum      = w_cw ? (w_cnt_ext + w_step_ext) : (w_cnt_ext - w_step_ext);

    always_comb begin
        if (w_sum > COUNT_MAX) begin
            w_sat = COUNT_MAX[CountW-1:0];
        end else if (w_sum < COUNT_MIN) begin
            w_sat = COUNT_MIN[CountW-1:0];
        end else begin
            w_sat = w_sum[CountW-1:0];
        end
    end

    always_comb begin
        o_state.hist  = w_change ? w_hist_sh : i_state.hist;
        o_state.count = (w_cw || w_ccw) ? w_sat : w_cnt0;
        if (w_cw || w_ccw) begin
            o_state.idle = '0;
        end else if (!w_change && (i_state.idle != IDLE_MAX)) begin
            o_state.idle = i_state.idle + IdleW'(1);
        end else begin
            o_state.idle = i_state.idle;
        end
    end

    always_comb begin
        o_result.count = o_state.count;
        if (w_cw) begin
            o_result.detent_dir = DIR_CW;
        end else if (w_ccw) begin
            o_result.detent_dir = DIR_CCW;
        end else begin
            o_result.detent_dir = DIR_NONE;
        end
        o_result.fast_turn = (w_cw || w_ccw) && !w_slow;
    end

endmodule

`default_nettype wire

// ===== src/rotary_encoder_accel_counter_core.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_accel_counter_core
// Quadrature encoder decoder with turn-speed acceleration and a saturating
// signed detent counter.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      pin_a, pin_b, clear_count
//  m_axis    out  m_axis_tvalid/tready      count, detent_dir, fast_turn
//  apb       in   psel/penable/pwrite       slow_threshold, fast_step
//
//  one request per cycle sustained while m_axis_tready holds; each accepted
//  sample passes the input register, then the result register
//  the state update sits between the input and result registers
//  synchronous active-low reset clears state, valids and config registers
//  a stalled output holds its result while one more sample waits in the input
//  register
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_encoder_accel_counter_core
    import rec_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // pin_a, pin_b, clear_count, zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // count[7:0], detent_dir[9:8], fast_turn, pad
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg    w_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result w_res;
    t_result r_res;
    t_item   r_item;
    logic    r_in_vld;
    logic    r_out_vld;
    logic    w_adv;
    logic    w_fire;

    rec_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rec_step u_step (
        .i_cfg    (w_cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (w_res)
    );

    assign w_adv         = !r_out_vld || m_axis_tready;
    assign w_fire        = r_in_vld && w_adv;
    assign s_axis_tready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_vld <= r_in_vld;
            end
            if (w_fire) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item <= t_item'(s_axis_tdata[2:0]);
        end
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'd0, r_res};

    a_dir_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_res.detent_dir != 2'd3))
        else $error("detent direction code out of range");

    a_fast_needs_detent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.fast_turn) |-> (r_res.detent_dir != DIR_NONE))
        else $error("fast turn flagged without a detent");

    a_idle_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (w_res.detent_dir != DIR_NONE)) |=> (r_state.idle == '0))
        else $error("idle count not cleared after detent");

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_res.count == r_state.count))
        else $error("reported count differs from accumulator");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the rotary encoder detent counter. A short scripted
// turn sequence runs first, then randomized turns, bounces and pin noise
// under several threshold and step settings. Every output request is checked
// field by field against the scripted result or a behavioral decoder kept alongside the stimulus.
// ----------------------------------------------------------------------------

module tb;
    import rec_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 220;

    typedef struct packed {
        logic                     pin_a;
        logic                     pin_b;
        logic                     clr;
        logic                     known;
        logic signed [CountW-1:0] count;
        logic [DirW-1:0]          dir;
        logic                     fast;
    } t_script_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // pin_a, pin_b, clear_count, zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // count[7:0], detent_dir[9:8], fast_turn, pad
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // decoder state and register copies
    logic [HistW-1:0]         track_hist;
    logic [IdleW-1:0]         track_idle;
    logic signed [CountW-1:0] track_count;
    logic [ThrW-1:0]          cfg_thr;
    logic [StepW-1:0]         cfg_step;

    t_result decoded_q[$];
    int      n_bad = 0;
    int      quiet_cycles = 0;
    bit      calm_tx = 1'b0;
    bit      calm_rx = 1'b0;
    bit      hold_req = 1'b0;
    bit      hold_taken = 1'b0;
    int      hold_left = 0;

    t_script_row script [25];
    int          thr_plan [6] = '{0, 255, 3, -1, 20, 6};
    int          step_plan [6] = '{127, 1, 0, -1, 64, 4};

    rotary_encoder_accel_counter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_result decode_tick(input t_item smp);
        logic [1:0]        io;
        logic [7:0]        step;
        logic signed [9:0] sum;
        t_result           res;
        io = {smp.pin_b, smp.pin_a};
        res = '0;
        if (smp.clear_count) track_count = '0;
        if (track_hist[1:0] != io) begin
            track_hist = {track_hist[5:0], io};
            if (track_hist == PAT_CW || track_hist == PAT_CCW) begin
                if (track_idle > cfg_thr) begin
                    step = 8'd1;
                end else begin
                    step = {1'b0, cfg_step};
                    res.fast_turn = 1'b1;
                end
                sum = {{2{track_count[7]}}, track_count};
                if (track_hist == PAT_CW) begin
                    res.detent_dir = DIR_CW;
                    sum = sum + $signed({2'b00, step});
                end else begin
                    res.detent_dir = DIR_CCW;
                    sum = sum - $signed({2'b00, step});
                end
                if (sum > COUNT_MAX) sum = COUNT_MAX;
                if (sum < COUNT_MIN) sum = COUNT_MIN;
                track_count = sum[7:0];
                track_idle = '0;
            end
        end else if (track_idle != IDLE_MAX) begin
            track_idle = track_idle + 1'b1;
        end
        res.count = track_count;
        return res;
    endfunction

    function automatic logic [1:0] step_pins(input logic [1:0] cur, input bit ccw);
        logic [1:0] nxt;
        case (cur)
            2'd3: nxt = ccw ? 2'd2 : 2'd1;
            2'd1: nxt = ccw ? 2'd3 : 2'd0;
            2'd0: nxt = ccw ? 2'd1 : 2'd2;
            default: nxt = ccw ? 2'd0 : 2'd3;
        endcase
        return nxt;
    endfunction

    // entered and left at a falling edge, tvalid left high after the request
    task automatic offer_sample(input t_item smp, input bit known, input t_result known_res);
        t_result pred;
        while (!calm_tx && $urandom_range(0, 99) < 37) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {5'b0, smp};
        do @(posedge i_clk); while (!s_axis_tready);
        pred = decode_tick(smp);
        decoded_q.push_back(known ? known_res : pred);
        @(negedge i_clk);
    endtask

    task automatic tick(input logic [1:0] io);
        t_item smp;
        smp.pin_a = io[0];
        smp.pin_b = io[1];
        smp.clear_count = ($urandom_range(0, 24) == 0);
        offer_sample(smp, 1'b0, '0);
    endtask

    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (decoded_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_SLOW_THRESHOLD) cfg_thr = val[7:0];
        else cfg_step = val[6:0];
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic turn_phase(input int n_items);
        int         sent;
        int         reps;
        int         r;
        int         pause_max;
        bit         ccw;
        logic [1:0] cur;
        logic [1:0] io;
        sent = 0;
        ccw = $urandom_range(0, 1);
        while (sent < n_items) begin
            cur = track_hist[1:0];
            r = $urandom_range(0, 99);
            if (r < 72) begin
                if ($urandom_range(0, 99) < 15) ccw = !ccw;
                io = step_pins(cur, ccw);
                tick(io);
                sent++;
                pause_max = int'(cfg_thr) + 2;
                if (pause_max > 260) pause_max = 260;
                if ($urandom_range(0, 11) == 0) reps = $urandom_range(0, pause_max);
                else if ($urandom_range(0, 99) < 60) reps = 0;
                else reps = $urandom_range(1, 3);
                repeat (reps) begin
                    tick(io);
                    sent++;
                end
            end else if (r < 86) begin
                // contact bounce: one step out and straight back
                tick(step_pins(cur, ccw));
                tick(cur);
                sent += 2;
            end else begin
                tick(2'($urandom_range(0, 3)));
                sent++;
            end
        end
    endtask

    // output side: readiness and the long hold-off
    always @(negedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (calm_rx) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= 37);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[10:0]);
            if (decoded_q.size() == 0) begin
                $error("unexpected result request, tdata %h", m_axis_tdata);
                n_bad++;
            end else begin
                want = decoded_q.pop_front();
                if (got.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, got.count);
                    n_bad++;
                end
                if (got.detent_dir !== want.detent_dir) begin
                    $error("detent_dir: expected %0d, got %0d", want.detent_dir,
                           got.detent_dir);
                    n_bad++;
                end
                if (got.fast_turn !== want.fast_turn) begin
                    $error("fast_turn: expected %0d, got %0d", want.fast_turn,
                           got.fast_turn);
                    n_bad++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_item   smp;
        t_result res;
        int      thr;
        int      step;

        // pin_a, pin_b, clear, known, count, dir, fast
        script = '{
            '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, DIR_NONE, 1'b0},
            '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, DIR_NONE, 1'b0},
            '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, DIR_NONE, 1'b0},
            '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, DIR_NONE, 1'b0},
            '{1'b0, 1'b1, 1'b0, 1'b1, 8'h04, DIR_CW,   1'b1},
            '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, DIR_NONE, 1'b0},
            '{1'b0, 1'b1, 1'b0, 1'b0, 8'h00, DIR_NONE, 1'b0},
            '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, DIR_NONE, 1'b0},
            '{1'b1, 1'b0, 1'b0, 1'b1, 8'h00, DIR_CCW,  1'b1},
            '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, DIR_NONE, 1'b0},
            '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, DIR_NONE, 1'b0},
            '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, DIR_NONE, 1'b0},
            '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, DIR_NONE, 1'b0},
            '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, DIR_NONE, 1'b0},
            '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, DIR_NONE, 1'b0},
            '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, DIR_NONE, 1'b0},
            '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, DIR_NONE, 1'b0},
            '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, DIR_NONE, 1'b0},
            '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, DIR_NONE, 1'b0},
            '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, DIR_NONE, 1'b0},
            '{1'b0, 1'b1, 1'b0, 1'b1, 8'h01, DIR_CW,   1'b0},
            '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, DIR_NONE, 1'b0},
            '{1'b0, 1'b1, 1'b0, 1'b0, 8'h00, DIR_NONE, 1'b0},
            '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, DIR_NONE, 1'b0},
            '{1'b1, 1'b0, 1'b1, 1'b1, 8'hFC, DIR_CCW,  1'b1}
        };

        cfg_thr = THR_RESET;
        cfg_step = STEP_RESET;
        track_hist = '0;
        track_idle = '0;
        track_count = '0;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // scripted turns under reset settings
        foreach (script[k]) begin
            smp.pin_a = script[k].pin_a;
            smp.pin_b = script[k].pin_b;
            smp.clear_count = script[k].clr;
            res.count = script[k].count;
            res.detent_dir = script[k].dir;
            res.fast_turn = script[k].fast;
            offer_sample(smp, script[k].known, res);
        end

        for (int p = 0; p < 6; p++) begin
            drain_results();
            thr = (thr_plan[p] < 0) ? $urandom_range(0, 255) : thr_plan[p];
            step = (step_plan[p] < 0) ? $urandom_range(0, 127) : step_plan[p];
            write_reg(REG_SLOW_THRESHOLD, ($urandom & ~32'hFF) | 32'(thr));
            write_reg(REG_FAST_STEP, ($urandom & ~32'h7F) | 32'(step));
            calm_tx = (p == 4);
            calm_rx = (p == 4);
            if (p == 1) hold_req = 1'b1;
            turn_phase(PHASE_ITEMS);
            calm_tx = 1'b0;
            calm_rx = 1'b0;
        end

        drain_results();
        repeat (8) @(negedge i_clk);
        if (n_bad == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
